// File: sv/rmst_pkg.sv
package rmst_pkg;

  // Field widths of the word on each channel
  localparam int unsigned POS_W = 11;
  localparam int unsigned VAL_W = 31;

  // Operation codes
  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET,
    ST_QL,
    ST_QR
  } rmst_state_e;

endpackage

// File: sv/rmst_ram.sv
module rmst_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write one entry, register one read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/range_max_segment_tree_unit.sv
// Point-update, range-maximum store kept as a binary max tree in one RAM.
// Set word: one tree level per cycle, with the sibling read overlapped with the parent
// write. Query word: two node reads per level on one read port.
// One word in flight at a time; the result register frees the input side.
// Reset: a pass over every RAM entry zeroes the RAM, input stalled.
module range_max_segment_tree_unit #(
  parameter int unsigned LEAVES = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      op_i,
  input  logic [rmst_pkg::POS_W-1:0] left_pos_i,
  input  logic [rmst_pkg::POS_W-1:0] right_pos_i,
  input  logic [rmst_pkg::VAL_W-1:0] new_value_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [rmst_pkg::VAL_W-1:0] range_max_o
);

  import rmst_pkg::*;

  localparam int unsigned LVL   = $clog2(LEAVES);
  localparam int unsigned NP    = 1 << LVL;
  localparam int unsigned DEPTH = 2 * NP;
  localparam int unsigned NW    = LVL + 1;
  localparam int unsigned PW    = LVL + 2;
  localparam int unsigned XW    = (PW > POS_W) ? PW : POS_W;

  rmst_state_e      state_q, state_d;
  logic [NW-1:0]    clr_q, clr_d;
  logic [NW-1:0]    k_q, k_d;
  logic [VAL_W-1:0] cur_q, cur_d;
  logic [PW-1:0]    l_q, l_d, r_q, r_d;
  logic [VAL_W-1:0] best_q, best_d;
  logic             lpend_q, lpend_d, rpend_q, rpend_d;
  logic             out_valid_q;
  logic [VAL_W-1:0] out_data_q;

  logic             we;
  logic [NW-1:0]    waddr, raddr;
  logic [VAL_W-1:0] wdata, rdata;
  logic             load;
  logic [VAL_W-1:0] load_val;
  logic             accept;

  logic [XW-1:0]    left_x, right_x, lo_x, hi_x;
  logic             set_ok, q_ok;
  logic [PW-1:0]    leaf_p, ql_p, qr_p, rm1_p;
  logic [NW-1:0]    leaf, par;
  logic [VAL_W-1:0] set_max, ql_best, qr_best;

  rmst_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_tree (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Take a word only when idle and the result register will be free
  assign in_stall_o = (state_q != ST_IDLE) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;

  // Check the position, clip the query range and map to tree nodes
  always_comb begin
    left_x  = XW'(left_pos_i);
    right_x = XW'(right_pos_i);
    set_ok  = (left_x != '0) && (left_x <= XW'(LEAVES));
    lo_x    = (left_x == '0) ? XW'(1) : left_x;
    hi_x    = (right_x > XW'(LEAVES)) ? XW'(LEAVES) : right_x;
    q_ok    = (lo_x <= hi_x);
    leaf_p  = PW'(NP) + left_x[PW-1:0] - PW'(1);
    leaf    = leaf_p[NW-1:0];
    ql_p    = PW'(NP) + lo_x[PW-1:0] - PW'(1);
    qr_p    = PW'(NP) + hi_x[PW-1:0];
    rm1_p   = r_q - PW'(1);
    par     = {1'b0, k_q[NW-1:1]};
    set_max = (rdata > cur_q) ? rdata : cur_q;
    ql_best = (rpend_q && (rdata > best_q)) ? rdata : best_q;
    qr_best = (lpend_q && (rdata > best_q)) ? rdata : best_q;
  end

  // Sequence the tree walk
  always_comb begin
    state_d  = state_q;
    clr_d    = clr_q;
    k_d      = k_q;
    cur_d    = cur_q;
    l_d      = l_q;
    r_d      = r_q;
    best_d   = best_q;
    lpend_d  = lpend_q;
    rpend_d  = rpend_q;
    we       = 1'b0;
    waddr    = '0;
    wdata    = '0;
    raddr    = '0;
    load     = 1'b0;
    load_val = '0;
    case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        clr_d = clr_q + NW'(1);
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (op_i == OP_SET) begin
            if (set_ok) begin
              // write the leaf and fetch its sibling in the same cycle
              we      = 1'b1;
              waddr   = leaf;
              wdata   = new_value_i;
              raddr   = {leaf[NW-1:1], ~leaf[0]};
              k_d     = leaf;
              cur_d   = new_value_i;
              state_d = ST_SET;
            end else begin
              load = 1'b1;
            end
          end else begin
            if (q_ok) begin
              l_d     = ql_p;
              r_d     = qr_p;
              best_d  = '0;
              rpend_d = 1'b0;
              state_d = ST_QL;
            end else begin
              load = 1'b1;
            end
          end
        end
      end
      ST_SET: begin
        // write the parent maximum, fetch the parent's sibling
        we    = 1'b1;
        waddr = par;
        wdata = set_max;
        cur_d = set_max;
        k_d   = par;
        raddr = {par[NW-1:1], ~par[0]};
        if (par == NW'(1)) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_QL: begin
        best_d = ql_best;
        if (l_q < r_q) begin
          lpend_d = l_q[0];
          raddr   = l_q[NW-1:0];
          state_d = ST_QR;
        end else begin
          load     = 1'b1;
          load_val = ql_best;
          state_d  = ST_IDLE;
        end
      end
      ST_QR: begin
        // absorb the left node, fetch the right node, climb one level
        best_d  = qr_best;
        rpend_d = r_q[0];
        raddr   = rm1_p[NW-1:0];
        l_d     = (l_q + PW'(l_q[0])) >> 1;
        r_d     = r_q >> 1;
        state_d = ST_QL;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Advance the walk registers and the result word
  always_ff @(posedge clk_i) begin
    k_q     <= k_d;
    cur_q   <= cur_d;
    l_q     <= l_d;
    r_q     <= r_d;
    best_q  <= best_d;
    lpend_q <= lpend_d;
    rpend_q <= rpend_d;
    if (load) begin
      out_data_q <= load_val;
    end
  end

  assign out_valid_o = out_valid_q;
  assign range_max_o = out_data_q;

endmodule

// File: bench/range_max_segment_tree_unit_tb.sv
module range_max_segment_tree_unit_tb;
  import rmst_pkg::*;

  localparam int unsigned LEAVES = 1024;
  localparam int unsigned LEAF_SPAN = 1 << $clog2(LEAVES);
  localparam int unsigned POS_TOP = (1 << POS_W) - 1;
  localparam int unsigned RANDOM_WORDS = 830;
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef struct packed {
    logic             op;
    logic [POS_W-1:0] left_pos;
    logic [POS_W-1:0] right_pos;
    logic [VAL_W-1:0] new_value;
  } tree_word_t;

  typedef struct {
    tree_word_t       word;
    logic [VAL_W-1:0] range_max;
  } range_max_due_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             op_i = OP_SET;
  logic [POS_W-1:0] left_pos_i = '0;
  logic [POS_W-1:0] right_pos_i = '0;
  logic [VAL_W-1:0] new_value_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [VAL_W-1:0] range_max_o;

  // Words waiting to go out, and query answers waiting to come back
  tree_word_t     word_backlog[$];
  range_max_due_t range_max_due[$];

  // Shadow max tree, node 1 is the root, leaves at [LEAF_SPAN, 2*LEAF_SPAN)
  logic [VAL_W-1:0] max_tree [1:2*LEAF_SPAN-1];

  int unsigned mismatches = 0;
  int unsigned sets_taken = 0;
  int unsigned queries_taken = 0;
  int unsigned nonzero_answers = 0;
  int unsigned results_seen = 0;

  range_max_segment_tree_unit #(
    .LEAVES(LEAVES)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .op_i       (op_i),
    .left_pos_i (left_pos_i),
    .right_pos_i(right_pos_i),
    .new_value_i(new_value_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .range_max_o(range_max_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Write one leaf and rebuild the maxima up to the root; drop bad positions
  function automatic void tree_store(int unsigned pos, logic [VAL_W-1:0] val);
    int unsigned k;
    if (pos < 1 || pos > LEAVES) return;
    k = LEAF_SPAN + pos - 1;
    max_tree[k] = val;
    while (k > 1) begin
      k = k >> 1;
      max_tree[k] = (max_tree[2*k] > max_tree[2*k+1]) ? max_tree[2*k] : max_tree[2*k+1];
    end
  endfunction

  // Maximum over an inclusive range, clipped to 1..LEAVES; empty gives zero
  function automatic logic [VAL_W-1:0] tree_range_max(int unsigned lo, int unsigned hi);
    int unsigned l;
    int unsigned r;
    logic [VAL_W-1:0] best;
    best = '0;
    if (lo < 1) lo = 1;
    if (hi > LEAVES) hi = LEAVES;
    if (lo > hi) return '0;
    l = LEAF_SPAN + lo - 1;
    r = LEAF_SPAN + hi;
    while (l < r) begin
      if ((l & 1) != 0) begin
        if (max_tree[l] > best) best = max_tree[l];
        l++;
      end
      if ((r & 1) != 0) begin
        r--;
        if (max_tree[r] > best) best = max_tree[r];
      end
      l = l >> 1;
      r = r >> 1;
    end
    return best;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 20) $display("%0t mismatch: %s", $time, what);
  endtask

  // Idle length: mostly short, a few long
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  function automatic void push_word(logic op, int unsigned lp, int unsigned rp,
                                    logic [VAL_W-1:0] val);
    tree_word_t w;
    w.op = op;
    w.left_pos = lp[POS_W-1:0];
    w.right_pos = rp[POS_W-1:0];
    w.new_value = val;
    word_backlog.push_back(w);
  endfunction

  function automatic int unsigned rand_pos();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, LEAVES);
    if (r < 82) return 0;
    if (r < 90) return $urandom_range(LEAVES + 1, POS_TOP);
    return $urandom_range(0, 1) ? 1 : LEAVES;
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    logic [31:0] raw;
    int unsigned r;
    raw = $urandom();
    r = $urandom_range(0, 99);
    if (r < 75) return raw[VAL_W-1:0];
    if (r < 90) return VAL_W'($urandom_range(0, 15));
    if (r < 95) return '1;
    return '0;
  endfunction

  // Mostly sets and tight queries with random content, some wild bounds
  function automatic void push_random_word();
    int unsigned lp;
    int unsigned rp;
    int unsigned r;
    lp = rand_pos();
    r = $urandom_range(0, 99);
    if (r < 50) rp = (lp + $urandom_range(0, 40) > POS_TOP) ? POS_TOP : lp + $urandom_range(0, 40);
    else if (r < 75) rp = $urandom_range(0, POS_TOP);
    else rp = $urandom_range(1, LEAVES);
    push_word(($urandom_range(0, 99) < 45) ? OP_SET : OP_QUERY, lp, rp, rand_value());
  endfunction

  // Driver: hold a stalled word, predict on acceptance, then idle or advance
  always @(posedge clk_i) begin : driver
    int unsigned send_gap;
    bit send_free;
    bit accepted;
    tree_word_t w;
    range_max_due_t due;
    if (rst_ni) begin
      accepted = in_valid_i && !in_stall_o;
      if (accepted) begin
        due.word = '{op_i, left_pos_i, right_pos_i, new_value_i};
        if (op_i == OP_SET) begin
          tree_store(left_pos_i, new_value_i);
          due.range_max = '0;
          sets_taken++;
        end else begin
          due.range_max = tree_range_max(left_pos_i, right_pos_i);
          queries_taken++;
          if (due.range_max != 0) nonzero_answers++;
        end
        range_max_due.push_back(due);
      end
      if (in_valid_i && !accepted) begin
        // hold the stalled word
      end else if (send_gap > 0) begin
        in_valid_i <= 1'b0;
        send_gap--;
      end else if (word_backlog.size() != 0) begin
        w = word_backlog.pop_front();
        op_i <= w.op;
        left_pos_i <= w.left_pos;
        right_pos_i <= w.right_pos;
        new_value_i <= w.new_value;
        in_valid_i <= 1'b1;
        if ($urandom_range(0, 63) == 0) send_free = !send_free;
        send_gap = (send_free || $urandom_range(0, 1)) ? 0 : idle_len();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Monitor: check each taken result against the oldest expectation, drive stall
  always @(posedge clk_i) begin : monitor
    int unsigned hold_cnt;
    bit recv_free;
    range_max_due_t due;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (range_max_due.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", range_max_o));
        end else begin
          due = range_max_due.pop_front();
          if (range_max_o !== due.range_max)
            report_mismatch($sformatf("op %0d left %0d right %0d value %0d: range_max %0d, want %0d",
                                      due.word.op, due.word.left_pos, due.word.right_pos,
                                      due.word.new_value, range_max_o, due.range_max));
        end
        if ($urandom_range(0, 63) == 0) recv_free = !recv_free;
      end
      if (hold_cnt > 0) begin
        out_stall_i <= 1'b1;
        hold_cnt--;
      end else if (!recv_free && $urandom_range(0, 3) == 0) begin
        out_stall_i <= 1'b1;
        hold_cnt = idle_len() - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    for (int i = 1; i < 2 * LEAF_SPAN; i++) max_tree[i] = '0;

    // Directed: empty tree, end positions, ignored sets, clipping, empty ranges
    push_word(OP_QUERY, 1, LEAVES, '0);
    push_word(OP_SET, 1, 0, '1);
    push_word(OP_SET, LEAVES, POS_TOP, 31'h2AAA_AAAA);
    push_word(OP_QUERY, 1, 1, '0);
    push_word(OP_QUERY, LEAVES, LEAVES, '1);
    push_word(OP_QUERY, 2, LEAVES, '0);
    push_word(OP_SET, 0, 5, 31'd123);
    push_word(OP_SET, LEAVES + 1, 0, '1);
    push_word(OP_SET, POS_TOP, POS_TOP, '1);
    push_word(OP_QUERY, 0, POS_TOP, '1);
    push_word(OP_QUERY, LEAVES + 1, POS_TOP, '0);
    push_word(OP_QUERY, 0, 0, '0);
    push_word(OP_QUERY, 600, 10, '0);
    push_word(OP_SET, 1, 1, '0);
    push_word(OP_QUERY, 1, LEAVES, '0);
    push_word(OP_SET, 512, 0, 31'h5555_5555);
    push_word(OP_SET, 513, 0, 31'd1);
    push_word(OP_QUERY, 513, LEAVES, '0);
    push_word(OP_QUERY, 2, 511, '0);
    push_word(OP_QUERY, 512, 512, '0);
    push_word(OP_SET, LEAVES, 0, '0);
    push_word(OP_QUERY, 0, POS_TOP, '1);
    push_word(OP_QUERY, 1, 1023, 31'h2AAA_AAAA);

    for (int i = 0; i < RANDOM_WORDS; i++) push_random_word();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (word_backlog.size() != 0 || in_valid_i || range_max_due.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d sets and %0d queries (%0d with a nonzero max), %0d results checked",
             sets_taken, queries_taken, nonzero_answers, results_seen);
    if (mismatches == 0) begin
      $display("range_max_segment_tree_unit_tb: PASS");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("range_max_segment_tree_unit_tb: FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d words pending and %0d results due",
             word_backlog.size(), range_max_due.size());
    $display("range_max_segment_tree_unit_tb: FAIL");
    $finish;
  end

endmodule
